@@ hdl/opc_pkg.sv @@
// Shared types and constants for the optimal path counter.
`default_nettype none

package opc_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int COUNT_BITS = 64;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = 16;
    localparam int CCFG_W     = 11;
    localparam int CMP_W      = (COL_W + 1 > CCFG_W) ? COL_W + 1 : CCFG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_W       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    // line buffer write port
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        count_t           data;
    } lb_wr_t;

    // per-cell flags plus neighbor existence
    typedef struct packed {
        logic on_trace;
        logic from_top;
        logic from_diag;
        logic from_left;
        logic has_top;
        logic has_left;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/opc_line_buf.sv @@
// Previous-row count buffer with a clearing sweep after reset.
`default_nettype none

module opc_line_buf (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        rd_en,
    input  wire  [opc_pkg::COL_W-1:0]  rd_addr,
    output opc_pkg::count_t            rd_data,
    input  opc_pkg::lb_wr_t            wr,
    output logic                       busy
);
    import opc_pkg::*;

    localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_COLS - 1);

    count_t           mem [MAX_COLS];
    count_t           rd_data_reg;
    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [COL_W-1:0] clr_addr_reg;
    logic [COL_W-1:0] clr_addr_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

@@ hdl/opc_cell_calc.sv @@
// Saturating three-way sum of gated neighbor counts for one cell.
`default_nettype none

module opc_cell_calc (
    input  opc_pkg::cell_ctl_t ctl,
    input  opc_pkg::count_t    top,
    input  opc_pkg::count_t    diag,
    input  opc_pkg::count_t    left,
    output opc_pkg::count_t    path_count,
    output logic               saturated
);
    import opc_pkg::*;

    count_t                top_g;
    count_t                diag_g;
    count_t                left_g;
    logic                  origin;
    logic [COUNT_BITS+1:0] sum;

    always_comb
    begin
        top_g  = (ctl.on_trace && ctl.has_top && ctl.from_top) ? top : '0;
        diag_g = (ctl.on_trace && ctl.has_top && ctl.has_left && ctl.from_diag) ? diag : '0;
        left_g = (ctl.on_trace && ctl.has_left && ctl.from_left) ? left : '0;
        origin = ctl.on_trace && !ctl.has_top && !ctl.has_left;
        sum    = {2'b00, top_g} + {2'b00, diag_g} + {2'b00, left_g}
               + {{(COUNT_BITS + 1){1'b0}}, origin};
        // any carry past the count width means the limit was crossed
        path_count = (sum[COUNT_BITS+1:COUNT_BITS] != 2'b00) ? COUNT_MAX
                                                             : sum[COUNT_BITS-1:0];
        saturated  = (path_count == COUNT_MAX);
    end

endmodule

`default_nettype wire

@@ hdl/optimal_path_counter.sv @@
// Top level of the optimal path counter: position tracking, cell stage, output register.
`default_nettype none

// Counts co-optimal alignment paths over a traceback grid streamed in row-major
// order, one cell per s_* transaction and one result per m_* transaction. A new
// cell is accepted every clock unless the line buffer is clearing or a stalled
// result holds the cell stage; each cell passes through the cell stage and the
// output register. The previous-row line buffer is read at accept time with a
// registered read; the saturating three-input add is combinational. After
// reset the line buffer is swept to zero across all MAX_COLS (1024) entries,
// during which s_tready stays low; configuration writes are taken at any time.
// Program row_count (index 0) and col_count (index 1) only while the block is
// idle. m_tlast marks the bottom-right cell, whose count is the answer; m_tuser
// flags a count that sits at the saturation limit. A size of 0 acts as 1 and a
// column count above MAX_COLS acts as MAX_COLS.
module optimal_path_counter (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration write channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [opc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [opc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // cell input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: on_trace, from_top, from_diag, from_left, zero pad
    input  wire  [opc_pkg::IN_W-1:0]         s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // fields from bit 0: path_count
    output logic [opc_pkg::COUNT_BITS-1:0]   m_tdata,
    // fields from bit 0: saturated
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import opc_pkg::*;

    // configuration
    logic [ROW_W-1:0]  row_count_reg;
    logic [CCFG_W-1:0] col_count_reg;
    logic [ROW_W-1:0]  rows_eff;
    logic [CMP_W-1:0]  cols_eff;

    // position of the next cell to be accepted
    logic [COL_W-1:0]  col_index_reg;
    logic [COL_W-1:0]  col_index_next;
    logic [ROW_W-1:0]  row_index_reg;
    logic [ROW_W-1:0]  row_index_next;
    logic              last_col;
    logic              last_row;

    // cell stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    cell_ctl_t         s1_ctl_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_final_reg;
    logic              s1_byp_reg;
    logic              s1_adv;

    // running neighbors
    count_t            left_count_reg;
    count_t            diag_count_reg;
    count_t            top_val;
    count_t            p;
    logic              p_sat;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    count_t            out_count_reg;
    logic              out_sat_reg;
    logic              out_final_reg;

    logic              accept;
    logic              lb_busy;
    count_t            lb_rd_data;
    lb_wr_t            lb_wr;
    cell_ctl_t         in_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_W'(1);
            col_count_reg <= CCFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data[ROW_W-1:0];
                CFG_COL_COUNT: col_count_reg <= cfg_data[CCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective grid size
    always_comb
    begin
        rows_eff = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
        cols_eff = CMP_W'(col_count_reg);
        if (col_count_reg == '0)
        begin
            cols_eff = CMP_W'(1);
        end
        else if (cols_eff > CMP_W'(MAX_COLS))
        begin
            cols_eff = CMP_W'(MAX_COLS);
        end
    end

    // handshake: the cell stage moves on whenever the output register frees up
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !lb_busy && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        last_col = (CMP_W'(col_index_reg) + CMP_W'(1)) >= cols_eff;
        last_row = ({1'b0, row_index_reg} + (ROW_W + 1)'(1)) >= {1'b0, rows_eff};

        col_index_next = col_index_reg;
        row_index_next = row_index_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_index_next = '0;
                row_index_next = last_row ? '0 : row_index_reg + ROW_W'(1);
            end
            else
            begin
                col_index_next = col_index_reg + COL_W'(1);
            end
        end

        in_ctl.on_trace  = s_tdata[0];
        in_ctl.from_top  = s_tdata[1];
        in_ctl.from_diag = s_tdata[2];
        in_ctl.from_left = s_tdata[3];
        in_ctl.has_top   = (row_index_reg != '0);
        in_ctl.has_left  = (col_index_reg != '0);

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_index_reg  <= '0;
            row_index_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_count_reg <= '0;
            diag_count_reg <= '0;
        end
        else
        begin
            col_index_reg <= col_index_next;
            row_index_reg <= row_index_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                left_count_reg <= p;
                diag_count_reg <= top_val;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg   <= in_ctl;
            s1_col_reg   <= col_index_reg;
            s1_final_reg <= last_col && last_row;
            // the cell ahead writes the same column this edge (single-column
            // grid): its count lands in left_count_reg, so take it from there
            s1_byp_reg   <= s1_adv && (s1_col_reg == col_index_reg);
        end
        if (s1_adv)
        begin
            out_count_reg <= p;
            out_sat_reg   <= p_sat;
            out_final_reg <= s1_final_reg;
        end
    end

    assign top_val = s1_byp_reg ? left_count_reg : lb_rd_data;

    assign lb_wr.en   = s1_adv;
    assign lb_wr.addr = s1_col_reg;
    assign lb_wr.data = p;

    opc_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_index_reg),
        .rd_data (lb_rd_data),
        .wr      (lb_wr),
        .busy    (lb_busy)
    );

    opc_cell_calc u_cell_calc (
        .ctl        (s1_ctl_reg),
        .top        (top_val),
        .diag       (diag_count_reg),
        .left       (left_count_reg),
        .path_count (p),
        .saturated  (p_sat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_final_reg;

endmodule

`default_nettype wire

@@ hdl/opc_checker.sv @@
// Port-level checker for the optimal path counter, bound to the top level.
`default_nettype none

module opc_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire  [opc_pkg::COUNT_BITS-1:0]   m_tdata,
    input wire                              m_tuser,
    input wire                              m_tlast
);
    import opc_pkg::*;

    // stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // stalled result holds its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // saturation flag agrees with the count
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata == COUNT_MAX)))
        else $error("saturation flag does not match count");

    // a result appears on an empty output only after a matching cell transaction
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching cell transaction");

endmodule

bind optimal_path_counter opc_checker u_opc_checker (.*);

`default_nettype wire
